>>> design/pwmc_pkg.sv
// ----------------------------------------------------------------------------
// pwmc_pkg
// Shared types and constants for the PWM period and pulse calculator.
// ----------------------------------------------------------------------------
package pwmc_pkg;

  localparam int FREQ_W   = 16;
  localparam int WIDTH_W  = 16;
  localparam int CHAN_W   = 2;
  localparam int PSC_W    = 9;
  localparam int RELOAD_W = 16;
  localparam int CMP_W    = 21;
  localparam int CLK_W    = 27;
  localparam int SHIFT_W  = 4;
  localparam int REG_W    = 2;

  // Configuration register indexes
  localparam logic [REG_W-1:0] REG_MAX_FREQ  = 2'd0;
  localparam logic [REG_W-1:0] REG_MAX_WIDTH = 2'd1;
  localparam logic [REG_W-1:0] REG_CLOCK     = 2'd2;

  // Channel select codes
  localparam logic [CHAN_W-1:0] CHAN_ONE = 2'd0;
  localparam logic [CHAN_W-1:0] CHAN_TWO = 2'd1;

  typedef struct packed {
    logic [FREQ_W-1:0]  frequency_hz;
    logic [WIDTH_W-1:0] pulse_width_us;
    logic [CHAN_W-1:0]  channel_select;
  } pwmc_in_t;

  typedef struct packed {
    logic                write_period;
    logic [PSC_W-1:0]    prescaler_value;
    logic [RELOAD_W-1:0] reload_value;
    logic [CMP_W-1:0]    compare_one;
    logic                write_compare_two;
    logic [CMP_W-1:0]    compare_two;
  } pwmc_out_t;

  // Request fields that ride alongside the reload divider
  typedef struct packed {
    logic              off;
    logic [CHAN_W-1:0] chan;
    logic [PSC_W-1:0]  psc;
    logic [CMP_W-1:0]  cmp;
  } pwmc_side_t;

endpackage

>>> design/pwmc_div.sv
// ----------------------------------------------------------------------------
// pwmc_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module pwmc_div import pwmc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CLK_W-1:0]    in_dividend,
  input  logic [FREQ_W-1:0]   in_divisor,
  input  pwmc_side_t          in_side,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RELOAD_W-1:0] out_quotient,
  output pwmc_side_t          out_side
);

  localparam int NSTG = CLK_W + 1;

  logic              v_r    [NSTG];
  logic [FREQ_W-1:0] rem_r  [NSTG];
  logic [FREQ_W-1:0] den_r  [NSTG];
  logic [CLK_W-1:0]  num_r  [NSTG];
  pwmc_side_t        side_r [NSTG];
  logic              rdy    [NSTG];

  logic [FREQ_W:0]   trial   [NSTG-1];
  logic              ge      [NSTG-1];
  logic [FREQ_W-1:0] rem_nxt [NSTG-1];
  logic [CLK_W-1:0]  num_nxt [NSTG-1];

  // One quotient bit per stage: shift in the next dividend bit, try subtract
  always_comb begin
    for (int s = 0; s < NSTG - 1; s++) begin
      trial[s]   = {rem_r[s], num_r[s][CLK_W-1]};
      ge[s]      = (trial[s] >= {1'b0, den_r[s]});
      rem_nxt[s] = ge[s] ? FREQ_W'(trial[s] - {1'b0, den_r[s]}) : trial[s][FREQ_W-1:0];
      num_nxt[s] = {num_r[s][CLK_W-2:0], ge[s]};
    end
  end

  // Stage advances when empty or when the next stage moves
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int s = NSTG - 2; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) begin
        v_r[s] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (rdy[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      rem_r[0]  <= '0;
      num_r[0]  <= in_dividend;
      den_r[0]  <= in_divisor;
      side_r[0] <= in_side;
    end
    for (int s = 1; s < NSTG; s++) begin
      if (rdy[s] && v_r[s-1]) begin
        rem_r[s]  <= rem_nxt[s-1];
        num_r[s]  <= num_nxt[s-1];
        den_r[s]  <= den_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign in_ready     = rdy[0];
  assign out_valid    = v_r[NSTG-1];
  assign out_quotient = num_r[NSTG-1][RELOAD_W-1:0];
  assign out_side     = side_r[NSTG-1];

endmodule

>>> design/pwm_period_and_pulse_calculator.sv
// ----------------------------------------------------------------------------
// pwm_period_and_pulse_calculator
// Turns a frequency / pulse width / channel request into PWM timer settings.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                              Moves
//  -------   ---------------------------------  ------------------------------
//  in        in_valid, in_ready, in_data        one request (pwmc_in_t)
//  out       out_valid, out_ready, out_data     one result per request
//  cfg       cfg_we, cfg_index, cfg_wdata       register write, no wait
//
//  A new request can be taken every clock unless a stall on out has backed
//  up to the front stage. Its result shows on out_data after the request
//  passes 30 registers: one front stage (clamps), 28 divider stages (a load
//  stage, then one quotient bit per stage for the 27-bit reload division)
//  and one output register. Reset (rst_n low at a clock edge) empties every
//  stage and loads the register defaults. A stall on out backs up stage by
//  stage; empty stages keep filling, so nothing is dropped or repeated.
//
module pwm_period_and_pulse_calculator import pwmc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pwmc_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pwmc_out_t        out_data,
  input  logic             cfg_we,
  input  logic [REG_W-1:0] cfg_index,
  input  logic [CLK_W-1:0] cfg_wdata
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [FREQ_W-1:0]  max_freq_r;
  logic [WIDTH_W-1:0] max_width_r;
  logic [CLK_W-1:0]   clock_hz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_freq_r  <= FREQ_W'(1000);
      max_width_r <= WIDTH_W'(200);
      clock_hz_r  <= CLK_W'(32000000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_FREQ:  max_freq_r  <= cfg_wdata[FREQ_W-1:0];
        REG_MAX_WIDTH: max_width_r <= cfg_wdata[WIDTH_W-1:0];
        REG_CLOCK:     clock_hz_r  <= cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Front stage: off detect, frequency clamp, upper width clamp
  // --------------------------------------------------------------------------
  logic               a_v_r;
  logic               a_off_r;
  logic [FREQ_W-1:0]  a_freq_r;
  logic [WIDTH_W-1:0] a_width_r;
  logic [CHAN_W-1:0]  a_chan_r;

  logic               a_off_nxt;
  logic [FREQ_W-1:0]  fmax;
  logic [FREQ_W-1:0]  a_freq_nxt;
  logic [WIDTH_W-1:0] a_width_nxt;
  logic               a_ready;
  logic               div_in_ready;

  always_comb begin
    a_off_nxt   = (in_data.frequency_hz == '0) || (in_data.pulse_width_us == '0);
    // A zero limit acts as one so the divisor never reaches zero
    fmax        = (max_freq_r == '0) ? FREQ_W'(1) : max_freq_r;
    a_freq_nxt  = (in_data.frequency_hz > fmax) ? fmax : in_data.frequency_hz;
    a_width_nxt = (in_data.pulse_width_us > max_width_r) ? max_width_r
                                                         : in_data.pulse_width_us;
  end

  assign a_ready  = !a_v_r || div_in_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_ready) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_off_r   <= a_off_nxt;
      a_freq_r  <= a_freq_nxt;
      a_width_r <= a_width_nxt;
      a_chan_r  <= in_data.channel_select;
    end
  end

  // --------------------------------------------------------------------------
  // Prescaler band, lower width clamp, compare, divider operands
  // Prescaler is 2^k - 1, so the reload is (clock >> k) / freq and the
  // compare is (width * 32) >> k, both exact.
  // --------------------------------------------------------------------------
  logic [SHIFT_W-1:0] shift;
  logic [PSC_W-1:0]   psc;
  logic [WIDTH_W-1:0] wmin;
  logic [WIDTH_W-1:0] width;
  logic [CMP_W-1:0]   cmp;
  logic [CLK_W-1:0]   dividend;
  pwmc_side_t         div_side_in;

  always_comb begin
    if      (a_freq_r == FREQ_W'(1))   shift = SHIFT_W'(9);
    else if (a_freq_r <= FREQ_W'(3))   shift = SHIFT_W'(8);
    else if (a_freq_r <= FREQ_W'(7))   shift = SHIFT_W'(7);
    else if (a_freq_r <= FREQ_W'(15))  shift = SHIFT_W'(6);
    else if (a_freq_r <= FREQ_W'(32))  shift = SHIFT_W'(5);
    else if (a_freq_r <= FREQ_W'(63))  shift = SHIFT_W'(4);
    else if (a_freq_r <= FREQ_W'(127)) shift = SHIFT_W'(3);
    else if (a_freq_r <= FREQ_W'(255)) shift = SHIFT_W'(2);
    else if (a_freq_r <= FREQ_W'(511)) shift = SHIFT_W'(1);
    else                               shift = SHIFT_W'(0);

    psc = PSC_W'((10'd1 << shift) - 10'd1);

    // Minimum width is 16/freq, floored at 5
    if      (a_freq_r == FREQ_W'(1)) wmin = WIDTH_W'(16);
    else if (a_freq_r == FREQ_W'(2)) wmin = WIDTH_W'(8);
    else                             wmin = WIDTH_W'(5);

    width    = (a_width_r < wmin) ? wmin : a_width_r;
    cmp      = {width, 5'b0} >> shift;
    dividend = clock_hz_r >> shift;

    div_side_in.off  = a_off_r;
    div_side_in.chan = a_chan_r;
    div_side_in.psc  = psc;
    div_side_in.cmp  = cmp;
  end

  // --------------------------------------------------------------------------
  // Reload divider
  // --------------------------------------------------------------------------
  logic                div_out_valid;
  logic                div_out_ready;
  logic [RELOAD_W-1:0] div_quot;
  pwmc_side_t          div_side_out;

  pwmc_div u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (a_v_r),
    .in_ready     (div_in_ready),
    .in_dividend  (dividend),
    .in_divisor   (a_freq_r),
    .in_side      (div_side_in),
    .out_valid    (div_out_valid),
    .out_ready    (div_out_ready),
    .out_quotient (div_quot),
    .out_side     (div_side_out)
  );

  // --------------------------------------------------------------------------
  // Output register: channel steering and the off case
  // --------------------------------------------------------------------------
  logic      out_valid_r;
  pwmc_out_t out_data_r;
  pwmc_out_t out_data_nxt;
  logic      sel_one;
  logic      sel_two;

  always_comb begin
    sel_one = !div_side_out.off && (div_side_out.chan == CHAN_ONE);
    sel_two = !div_side_out.off && (div_side_out.chan == CHAN_TWO);
    out_data_nxt.write_period      = !div_side_out.off;
    out_data_nxt.prescaler_value   = div_side_out.off ? '0 : div_side_out.psc;
    out_data_nxt.reload_value      = div_side_out.off ? '0 : div_quot;
    out_data_nxt.compare_one       = sel_one ? div_side_out.cmp : '0;
    // Off request still writes channel two's compare, as zero
    out_data_nxt.write_compare_two = div_side_out.off || sel_two;
    out_data_nxt.compare_two       = sel_two ? div_side_out.cmp : '0;
  end

  assign div_out_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_out_ready) begin
      out_valid_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_out_ready && div_out_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // An off result carries no period and zero compares
  a_off_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.write_period |->
      out_data_r.write_compare_two && (out_data_r.compare_one == '0) &&
      (out_data_r.compare_two == '0) && (out_data_r.reload_value == '0))
    else $error("off result carries nonzero settings");

  // At most one channel gets a compare value
  a_one_channel : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.compare_one == '0) || (out_data_r.compare_two == '0))
    else $error("both channel compares nonzero");

  // Prescaler is always a power of two minus one
  a_psc_pow2 : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ((out_data_r.prescaler_value & PSC_W'(out_data_r.prescaler_value + 1'b1)) == '0))
    else $error("prescaler not a power of two minus one");

  // A request can be taken whenever the front stage sits empty
  a_front_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !a_v_r |-> in_ready)
    else $error("front stage empty but request refused");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the PWM period and pulse calculator. Requests
// flow from a queue through a clocked driver. A clocked monitor compares every
// result against timer settings worked out here at the moment the request is
// taken. The run steps through several register settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import pwmc_pkg::*;

  localparam int STALL_LIMIT   = 4000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES  = 40;    // a little over the pipeline depth
  localparam int HOLDOFF_LEN   = 400;   // long receiver hold-off, well past pipeline depth
  localparam int PHASE_ITEMS   = 250;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  pwmc_in_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  pwmc_out_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [REG_W-1:0] cfg_index = REG_MAX_FREQ;
  logic [CLK_W-1:0] cfg_wdata = '0;

  // Local copy of the register file, kept in step with every write
  logic [FREQ_W-1:0]  freq_limit  = 16'd1000;
  logic [WIDTH_W-1:0] width_limit = 16'd200;
  logic [CLK_W-1:0]   timer_clock = 27'd32000000;

  pwmc_in_t  pending_requests[$];
  pwmc_out_t expected_settings[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holdoff_token  = 0;
  int unsigned holdoff_seen   = 0;
  int unsigned holdoff_left   = 0;
  int unsigned mismatch_count = 0;
  logic        in_taken       = 1'b0;

  pwm_period_and_pulse_calculator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the timer settings for one request under the current registers.
  function automatic pwmc_out_t predict_settings(pwmc_in_t req);
    pwmc_out_t       res;
    int unsigned     f;
    int unsigned     w;
    int unsigned     f_cap;
    int unsigned     w_floor;
    int unsigned     psc;
    int unsigned     cmp;
    longint unsigned reload;
    res = '0;
    // Off request: leave the period alone, clear both compares
    if (req.frequency_hz == 0 || req.pulse_width_us == 0) begin
      res.write_compare_two = 1'b1;
      return res;
    end
    f = req.frequency_hz;
    w = req.pulse_width_us;
    // A zero frequency limit behaves as one so the divisor never vanishes
    f_cap = (freq_limit == 0) ? 1 : freq_limit;
    if (f > f_cap) f = f_cap;
    w_floor = 16 / f;
    if (w_floor < 5) w_floor = 5;
    // Clamp down to the width limit first, then up to the floor: the floor wins
    if (w > width_limit) w = width_limit;
    if (w < w_floor) w = w_floor;
    if (f == 1)        psc = 511;
    else if (f <= 3)   psc = 255;
    else if (f <= 7)   psc = 127;
    else if (f <= 15)  psc = 63;
    else if (f <= 32)  psc = 31;
    else if (f <= 63)  psc = 15;
    else if (f <= 127) psc = 7;
    else if (f <= 255) psc = 3;
    else if (f <= 511) psc = 1;
    else               psc = 0;
    reload = 64'(timer_clock) / (64'(psc + 1) * 64'(f));
    cmp    = (w * 32) / (psc + 1);
    res.write_period      = 1'b1;
    res.prescaler_value   = PSC_W'(psc);
    res.reload_value      = RELOAD_W'(reload);
    res.compare_one       = (req.channel_select == CHAN_ONE) ? CMP_W'(cmp) : '0;
    res.write_compare_two = (req.channel_select == CHAN_TWO);
    res.compare_two       = (req.channel_select == CHAN_TWO) ? CMP_W'(cmp) : '0;
    return res;
  endfunction

  task automatic check_field(string name, longint unsigned exp_val, longint unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the next request at the falling edge. Hold valid and the
  // payload until the monitor has seen the handshake, then advance or idle.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall at random, or hold off for a long stretch when asked so
  // the pipeline fills and pushes back on the request side.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (holdoff_token != holdoff_seen) begin
      holdoff_seen = holdoff_token;
      holdoff_left = HOLDOFF_LEN;
    end
    if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at each rising edge check a finished result against the oldest
  // expectation, then record the expectation for a newly taken request.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pwmc_out_t exp_res;
    in_taken = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_settings.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        exp_res = expected_settings.pop_front();
        check_field("write_period", exp_res.write_period, out_data.write_period);
        check_field("prescaler_value", exp_res.prescaler_value, out_data.prescaler_value);
        check_field("reload_value", exp_res.reload_value, out_data.reload_value);
        check_field("compare_one", exp_res.compare_one, out_data.compare_one);
        check_field("write_compare_two", exp_res.write_compare_two,
                    out_data.write_compare_two);
        check_field("compare_two", exp_res.compare_two, out_data.compare_two);
      end
    end
    if (in_taken) expected_settings.push_back(predict_settings(in_data));
  end

  // Watchdog: give up when no handshake of either channel happens for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("pwm_period_and_pulse_calculator regression: fail");
    $finish;
  end

  // Write one register while the block is idle and mirror it locally.
  task automatic write_reg(logic [REG_W-1:0] index, logic [CLK_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (index)
      REG_MAX_FREQ:  freq_limit  = value[FREQ_W-1:0];
      REG_MAX_WIDTH: width_limit = value[WIDTH_W-1:0];
      REG_CLOCK:     timer_clock = value;
      default: ;
    endcase
  endtask

  task automatic queue_request(int unsigned f, int unsigned w, int unsigned c);
    pwmc_in_t req;
    req.frequency_hz   = FREQ_W'(f);
    req.pulse_width_us = WIDTH_W'(w);
    req.channel_select = CHAN_W'(c);
    pending_requests.push_back(req);
  endtask

  // Mix narrow ranges that land in every prescaler band with full-width noise
  function automatic pwmc_in_t random_request();
    pwmc_in_t    req;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0)      req.frequency_hz = '0;
    else if (pick < 8)  req.frequency_hz = FREQ_W'($urandom_range(1, 600));
    else if (pick < 12) req.frequency_hz = FREQ_W'($urandom_range(1, 40));
    else                req.frequency_hz = FREQ_W'($urandom);
    pick = $urandom_range(0, 19);
    if (pick == 0)      req.pulse_width_us = '0;
    else if (pick < 10) req.pulse_width_us = WIDTH_W'($urandom_range(1, 40));
    else                req.pulse_width_us = WIDTH_W'($urandom);
    req.channel_select = CHAN_W'($urandom_range(0, 3));
    return req;
  endfunction

  // Wait until every request is out and checked, then let the pipeline settle.
  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || expected_settings.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int unsigned n, int unsigned s_idle, int unsigned r_stall,
                            bit holdoff);
    @(posedge clk);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    if (holdoff) holdoff_token++;
    repeat (n) pending_requests.push_back(random_request());
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence: directed requests at reset settings, then random phases under
  // changing registers and idle patterns.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned band_edges[17];
    band_edges = '{2, 3, 4, 7, 8, 15, 16, 32, 33, 63, 64, 127, 128, 255, 256, 511, 512};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Off requests: zero frequency, zero width, both zero
    queue_request(0, 100, 0);
    queue_request(100, 0, 1);
    queue_request(0, 0, 3);
    // Lowest frequency lifts the width to its floor
    queue_request(1, 1, 0);
    queue_request(1, 1, 1);
    // Top of both fields, clamped, on channel one and both unused channel codes
    queue_request(65535, 65535, 0);
    queue_request(65535, 65535, 2);
    queue_request(65535, 65535, 3);
    // Prescaler band edges
    foreach (band_edges[i])
      queue_request(band_edges[i], 30 + i, i % 4);
    wait_idle();

    // Widest limits, 100 MHz clock; no idling, one long receiver hold-off
    write_reg(REG_MAX_FREQ, 27'd65535);
    write_reg(REG_MAX_WIDTH, 27'd65535);
    write_reg(REG_CLOCK, 27'd100000000);
    queue_request(65535, 65535, 1);
    queue_request(1, 1, 0);
    run_random(PHASE_ITEMS, 0, 0, 1'b1);

    // Zero frequency limit acts as one, zero clock, width floor above its limit
    write_reg(REG_MAX_FREQ, 27'd0);
    write_reg(REG_MAX_WIDTH, 27'd5);
    write_reg(REG_CLOCK, 27'd0);
    queue_request(1, 1, 0);
    queue_request(65535, 65535, 1);
    run_random(PHASE_ITEMS, 87, 0, 1'b0);

    // Random limits, slowest nominal clock; receiver mostly stalling
    write_reg(REG_MAX_FREQ, CLK_W'($urandom_range(1, 65535)));
    write_reg(REG_MAX_WIDTH, CLK_W'($urandom_range(5, 65535)));
    write_reg(REG_CLOCK, 27'd1000000);
    run_random(PHASE_ITEMS, 0, 87, 1'b0);

    // Zero width limit, all-ones clock; light idling on both sides
    write_reg(REG_MAX_FREQ, 27'd512);
    write_reg(REG_MAX_WIDTH, 27'd0);
    write_reg(REG_CLOCK, 27'h7FFFFFF);
    run_random(PHASE_ITEMS, 6, 6, 1'b0);

    // Fully random registers
    write_reg(REG_MAX_FREQ, CLK_W'($urandom_range(0, 65535)));
    write_reg(REG_MAX_WIDTH, CLK_W'($urandom_range(0, 65535)));
    write_reg(REG_CLOCK, CLK_W'($urandom));
    run_random(PHASE_ITEMS, 0, 0, 1'b0);

    if (mismatch_count == 0 && expected_settings.size() == 0) begin
      $display("pwm_period_and_pulse_calculator regression: pass");
    end else begin
      $display("pwm_period_and_pulse_calculator regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/pwmc_pkg.sv
design/pwmc_div.sv
design/pwm_period_and_pulse_calculator.sv
tb/sv/testbench.sv
